// File: rtl/mted_pkg.sv
package mted_pkg;
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W = $clog2(NUM_SLOTS + 1);
    localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] MODE_SYNC  = 2'd0;
    localparam logic [1:0] MODE_KEY   = 2'd1;
    localparam logic [1:0] MODE_ABS   = 2'd2;
    localparam logic [1:0] MODE_OTHER = 2'd3;

    localparam logic [9:0] ABS_X_C      = 10'd0;
    localparam logic [9:0] ABS_Y_C      = 10'd1;
    localparam logic [9:0] MT_SLOT_C    = 10'd47;
    localparam logic [9:0] ABS_MT_POS_X = 10'd53;
    localparam logic [9:0] ABS_MT_POS_Y = 10'd54;
    localparam logic [9:0] ABS_MT_TRK   = 10'd57;
    localparam logic [9:0] BTN_TOUCH_C  = 10'd330;
    localparam logic [9:0] SYN_REPORT_C = 10'd0;

    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_UP   = 2'd1;
    localparam logic [1:0] KIND_MOVE = 2'd2;
    localparam logic [1:0] KIND_ST   = 2'd3;

    localparam logic [2:0] REG_XMIN = 3'd0;
    localparam logic [2:0] REG_XMAX = 3'd1;
    localparam logic [2:0] REG_YMIN = 3'd2;
    localparam logic [2:0] REG_YMAX = 3'd3;
    localparam logic [2:0] REG_SW   = 3'd4;
    localparam logic [2:0] REG_SH   = 3'd5;
    localparam logic [2:0] REG_MT   = 3'd6;

    localparam int DIV_STEPS = 49;  // quotient magnitude < 2^49

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DIVX, ST_DIVY, ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       take;      // decode accepted word
        logic       scan_clr;  // reset slot pointer
        logic       scan_inc;  // advance slot pointer
        logic       div_x;     // start x divide
        logic       div_y;     // start y divide
        logic       load_out;  // load output register
        logic       out_last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sync_mt;     // word was a multitouch sync
        logic sync_st;     // word was a single-touch sync
        logic trk_res;     // word produced a down/up result
        logic scan_end;    // pointer past last slot
        logic slot_act;    // pointed slot is active
        logic more_act;    // an active slot exists after pointer
        logic can_scale;
        logic div_done;
        logic out_busy;
    } stat_t;
endpackage

// File: rtl/mted_ctrl.sv
module mted_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mted_pkg::stat_t st,
    output mted_pkg::cmd_t  cmd
);
    import mted_pkg::*;

    state_t state_reg, state_next;
    logic   mt_reg, mt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mt_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mt_reg    <= mt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mt_next    = mt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !st.out_busy) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // first cycle after accept: decode has settled
                if (st.trk_res) begin
                    state_next = ST_EMIT;
                    mt_next    = 1'b0;
                end else if (st.sync_st) begin
                    state_next = st.can_scale ? ST_DIVX : ST_EMIT;
                    mt_next    = 1'b0;
                end else if (st.sync_mt) begin
                    mt_next = 1'b1;
                    if (st.scan_end) begin
                        state_next = ST_IDLE;
                    end else if (st.slot_act) begin
                        state_next = st.can_scale ? ST_DIVX : ST_EMIT;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVX: if (st.div_done) state_next = ST_DIVY;
            ST_DIVY: if (st.div_done) state_next = ST_EMIT;
            ST_EMIT: begin
                if (!st.out_busy) begin
                    state_next = (mt_reg && st.more_act) ? ST_SCAN : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE) && !st.out_busy;
        cmd          = '0;
        cmd.take     = s_tvalid && s_tready;
        cmd.scan_clr = cmd.take;
        case (state_reg)
            ST_SCAN: begin
                if (st.sync_mt && !st.trk_res && !st.scan_end && !st.slot_act) begin
                    cmd.scan_inc = 1'b1;
                end
                if ((st.sync_st || (st.sync_mt && !st.scan_end && st.slot_act))
                    && st.can_scale && !st.trk_res) begin
                    cmd.div_x = 1'b1;
                end
            end
            ST_DIVX: cmd.div_y = st.div_done;
            ST_EMIT: begin
                cmd.load_out = !st.out_busy;
                cmd.out_last = !(mt_reg && st.more_act);
                cmd.scan_inc = !st.out_busy && mt_reg;
            end
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !st.out_busy) else $error("load over busy output");
    a_div_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_y |-> state_reg == ST_DIVX) else $error("y divide out of order");
endmodule

// File: rtl/mted_div.sv
module mted_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] raw,
    input  logic signed [31:0] lo,
    input  logic signed [31:0] hi,
    input  logic        [15:0] size,
    output logic               done,
    output logic        [31:0] quo
);
    import mted_pkg::*;

    // Stage 1 forms |(raw-lo)*size| (one 33x16 multiply), then restoring
    // division one bit a cycle.
    logic [48:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic [48:0] q_reg, q_next;
    logic [33:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        mul_reg, mul_next;
    logic signed [32:0] diff_reg, diff_next;
    logic        [15:0] size_reg, size_next;

    logic signed [49:0] prod;
    logic [33:0] trial;
    logic [48:0] qs;

    assign prod  = diff_reg * $signed({1'b0, size_reg});
    assign trial = {rem_reg[32:0], num_reg[48]} - {1'b0, den_reg};
    assign qs    = neg_reg ? (~q_reg + 49'd1) : q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
        end
        num_reg  <= num_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        diff_reg <= diff_next;
        size_reg <= size_next;
    end

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        mul_next  = 1'b0;
        diff_next = diff_reg;
        size_next = size_reg;
        done      = 1'b0;
        if (start) begin
            diff_next = 33'(raw) - 33'(lo);
            size_next = size;
            den_next  = 33'(33'(hi) - 33'(lo));
            mul_next  = 1'b1;
        end else if (mul_reg) begin
            neg_next  = prod[49];
            num_next  = prod[49] ? 49'(-prod) : prod[48:0];
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 6'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end else begin
                num_next = {num_reg[47:0], 1'b0};
                if (!trial[33]) begin
                    rem_next = trial;
                    q_next   = {q_reg[47:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[32:0], num_reg[48]};
                    q_next   = {q_reg[47:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    assign quo = qs[31:0];
endmodule

// File: rtl/mted_dp.sv
module mted_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic [47:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [167:0]       m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast,
    input  mted_pkg::cmd_t     cmd,
    output mted_pkg::stat_t    st
);
    import mted_pkg::*;

    logic signed [31:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic [15:0] sw_reg, sh_reg;
    logic        mt_reg;

    logic signed [31:0] cur_slot_reg;
    logic signed [31:0] tid_reg [NUM_SLOTS];
    logic signed [31:0] sx_reg  [NUM_SLOTS];
    logic signed [31:0] sy_reg  [NUM_SLOTS];
    logic signed [31:0] stx_reg, sty_reg;
    logic        contact_reg;

    logic        sync_mt_reg, sync_st_reg, trk_reg;
    logic signed [31:0] trk_val_reg;
    logic [5:0]  trk_slot_reg;
    logic [SLOT_W-1:0] ptr_reg;
    logic [31:0] px_reg, py_reg;
    logic        y_sel_reg;

    logic        ov_reg;
    logic [167:0] od_reg, od_next;
    logic [1:0]   okind_reg, okind_next;
    logic         ol_reg;

    logic [1:0]  mode;
    logic [9:0]  code;
    logic signed [31:0] val;
    logic        slot_ok;
    logic [SIDX_W-1:0] cidx, pidx;
    logic [NUM_SLOTS-1:0] act;
    logic        cscale;
    logic        div_start, div_done;
    logic signed [31:0] d_raw, d_lo, d_hi;
    logic [15:0] d_size;
    logic [31:0] d_quo;
    logic        div_go_reg;
    logic [NUM_SLOTS-1:0] after_mask;

    assign mode = s_tuser;
    assign code = s_tdata[9:0];
    assign val  = $signed(s_tdata[41:10]);
    assign slot_ok = !cur_slot_reg[31] && (cur_slot_reg < 32'(NUM_SLOTS));
    assign cidx = cur_slot_reg[SIDX_W-1:0];
    assign pidx = ptr_reg[SIDX_W-1:0];
    assign cscale = (sw_reg != 16'd0) && (sh_reg != 16'd0) &&
                    (xmax_reg > xmin_reg) && (ymax_reg > ymin_reg);

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) act[i] = !tid_reg[i][31];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xmin_reg <= '0; xmax_reg <= '0; ymin_reg <= '0; ymax_reg <= '0;
            sw_reg <= '0; sh_reg <= '0; mt_reg <= 1'b0;
            cur_slot_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tid_reg[i] <= -32'sd1;
                sx_reg[i]  <= '0;
                sy_reg[i]  <= '0;
            end
            stx_reg <= '0; sty_reg <= '0; contact_reg <= 1'b0;
            sync_mt_reg <= 1'b0; sync_st_reg <= 1'b0; trk_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_XMIN: xmin_reg <= cfg_wdata;
                    REG_XMAX: xmax_reg <= cfg_wdata;
                    REG_YMIN: ymin_reg <= cfg_wdata;
                    REG_YMAX: ymax_reg <= cfg_wdata;
                    REG_SW:   sw_reg   <= cfg_wdata[15:0];
                    REG_SH:   sh_reg   <= cfg_wdata[15:0];
                    REG_MT:   mt_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.take) begin
                sync_mt_reg <= (mode == MODE_SYNC) && (code == SYN_REPORT_C) && mt_reg;
                sync_st_reg <= (mode == MODE_SYNC) && (code == SYN_REPORT_C) && !mt_reg;
                trk_reg     <= (mode == MODE_ABS) && (code == ABS_MT_TRK) && slot_ok;
                trk_val_reg <= val;
                trk_slot_reg <= cur_slot_reg[5:0];
                if (mode == MODE_ABS) begin
                    case (code)
                        ABS_X_C:      stx_reg <= val;
                        ABS_Y_C:      sty_reg <= val;
                        MT_SLOT_C:    cur_slot_reg <= val;
                        ABS_MT_POS_X: if (slot_ok) sx_reg[cidx] <= val;
                        ABS_MT_POS_Y: if (slot_ok) sy_reg[cidx] <= val;
                        ABS_MT_TRK:   if (slot_ok) tid_reg[cidx] <= val;
                        default: ;
                    endcase
                end else if (mode == MODE_KEY && code == BTN_TOUCH_C) begin
                    contact_reg <= (val != 32'sd0);
                end
            end
            if (cmd.load_out) begin
                ov_reg <= 1'b1;
                ol_reg <= cmd.out_last;
                sync_st_reg <= 1'b0;
                trk_reg     <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // y_sel_reg tells which axis the finishing divide belongs to
    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) ptr_reg <= '0;
        else if (cmd.scan_inc && ptr_reg < SLOT_W'(NUM_SLOTS)) ptr_reg <= ptr_reg + 1'b1;
        if (div_done) begin
            if (y_sel_reg) py_reg <= d_quo;
            else px_reg <= d_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_x) y_sel_reg <= 1'b0;
        else if (cmd.div_y) y_sel_reg <= 1'b1;
    end

    always_comb begin
        logic [1:0]  k;
        logic [5:0]  sn;
        logic signed [31:0] id, rx, ry, ox, oy;
        logic sc, tch;
        if (trk_reg) begin
            k = trk_val_reg[31] ? KIND_UP : KIND_DOWN;
            sn = trk_slot_reg; id = trk_val_reg;
            rx = '0; ry = '0; sc = 1'b0; tch = 1'b0;
        end else if (sync_st_reg) begin
            k = KIND_ST; sn = '0; id = '0;
            rx = stx_reg; ry = sty_reg; sc = cscale; tch = contact_reg;
        end else begin
            k = KIND_MOVE; sn = 6'(ptr_reg); id = tid_reg[pidx];
            rx = sx_reg[pidx]; ry = sy_reg[pidx]; sc = cscale; tch = 1'b0;
        end
        ox = sc ? px_reg : '0;
        oy = sc ? py_reg : '0;
        okind_next = k;
        od_next = {tch, sc, oy, ox, ry, rx, id, sn};
    end

    assign d_raw  = sync_st_reg ? (y_sel_reg ? sty_reg : stx_reg)
                                : (y_sel_reg ? sy_reg[pidx] : sx_reg[pidx]);
    assign d_lo   = y_sel_reg ? ymin_reg : xmin_reg;
    assign d_hi   = y_sel_reg ? ymax_reg : xmax_reg;
    assign d_size = y_sel_reg ? sh_reg : sw_reg;
    assign div_start = cmd.div_x || cmd.div_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) div_go_reg <= 1'b0;
        else div_go_reg <= div_start;
    end

    mted_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg),
        .raw(d_raw), .lo(d_lo), .hi(d_hi), .size(d_size),
        .done(div_done), .quo(d_quo)
    );

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++)
            after_mask[i] = (SLOT_W'(i) > ptr_reg) && act[i];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            od_reg    <= od_next;
            okind_reg <= okind_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = ol_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = okind_reg;

    assign st.sync_mt   = sync_mt_reg;
    assign st.sync_st   = sync_st_reg;
    assign st.trk_res   = trk_reg;
    assign st.scan_end  = (ptr_reg >= SLOT_W'(NUM_SLOTS));
    assign st.slot_act  = (ptr_reg < SLOT_W'(NUM_SLOTS)) && act[pidx];
    assign st.more_act  = |after_mask;
    assign st.can_scale = cscale;
    assign st.div_done  = div_done;
    assign st.out_busy  = ov_reg && !m_tready;
endmodule

// File: rtl/multitouch_event_decoder.sv
// A word with no result frees the input after the scan state; a down/up
// word raises m_tvalid via scan and emit once the output register is free.
// Sync report: skipped slots step in scan; reported slots pass through emit,
// with scaling first through two passes of the shared bit-serial divider.
// Throughput: one input word in flight; ready returns after the last result.
// Reset: aresetn synchronous active low; clears config, slots (ids to -1).
module multitouch_event_decoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // event_code[9:0], event_value[41:10]
    input  logic [1:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // slot_number, track_id, raw_x, raw_y,
                                    // pixel_x, pixel_y, scaled, touching
    output logic [1:0]   m_tuser,   // report_kind
    output logic         m_tlast    // last
);
    import mted_pkg::*;

    cmd_t  cmd;
    stat_t st;

    mted_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid),
        .s_tready(s_tready), .st(st), .cmd(cmd)
    );

    mted_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast), .cmd(cmd), .st(st)
    );
endmodule

// File: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mted_pkg::*;

    // Expected-report store plus decoder state mirror.
    class touch_scoreboard;
        logic signed [31:0] x_min, x_max, y_min, y_max;
        logic [15:0]        scr_w, scr_h;
        logic               mt_on;
        logic signed [31:0] cur_slot;
        logic signed [31:0] trk_id [NUM_SLOTS];
        logic signed [31:0] sx [NUM_SLOTS];
        logic signed [31:0] sy [NUM_SLOTS];
        logic signed [31:0] st_x, st_y;
        logic               contact;
        logic [170:0]       pending_reports [$];  // {last, kind, tdata}
        int                 errors;

        function void clear();
            x_min = 0; x_max = 0; y_min = 0; y_max = 0;
            scr_w = 0; scr_h = 0; mt_on = 0;
            cur_slot = 0; st_x = 0; st_y = 0; contact = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                trk_id[i] = -1; sx[i] = 0; sy[i] = 0;
            end
            pending_reports.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_XMIN: x_min = v;
                REG_XMAX: x_max = v;
                REG_YMIN: y_min = v;
                REG_YMAX: y_max = v;
                REG_SW:   scr_w = v[15:0];
                REG_SH:   scr_h = v[15:0];
                REG_MT:   mt_on = v[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] to_pixels(logic signed [31:0] raw, logic signed [31:0] lo,
                                        logic signed [31:0] hi, logic [15:0] size);
            longint num, q;
            num = (longint'(raw) - longint'(lo)) * longint'({16'd0, size});
            q = num / (longint'(hi) - longint'(lo));
            return q[31:0];
        endfunction

        function void push(logic [1:0] kind, logic [5:0] slot, logic [31:0] id,
                           logic [31:0] rx, logic [31:0] ry, logic [31:0] px,
                           logic [31:0] py, logic sc, logic tch);
            pending_reports.push_back({1'b0, kind, tch, sc, py, px, ry, rx, id, slot});
        endfunction

        function void note_event(logic [1:0] mode, logic [9:0] code, logic signed [31:0] val);
            bit slot_ok, sc;
            int n;
            slot_ok = cur_slot >= 0 && cur_slot < NUM_SLOTS;
            sc = scr_w != 0 && scr_h != 0 && x_max > x_min && y_max > y_min;
            n = pending_reports.size();
            if (mode == MODE_ABS) begin
                case (code)
                    ABS_X_C:      st_x = val;
                    ABS_Y_C:      st_y = val;
                    MT_SLOT_C:    cur_slot = val;
                    ABS_MT_POS_X: if (slot_ok) sx[cur_slot] = val;
                    ABS_MT_POS_Y: if (slot_ok) sy[cur_slot] = val;
                    ABS_MT_TRK: if (slot_ok) begin
                        trk_id[cur_slot] = val;
                        push(val < 0 ? KIND_UP : KIND_DOWN, cur_slot[5:0], val,
                             '0, '0, '0, '0, 1'b0, 1'b0);
                    end
                    default: ;
                endcase
            end else if (mode == MODE_KEY) begin
                if (code == BTN_TOUCH_C) contact = val != 0;
            end else if (mode == MODE_SYNC && code == SYN_REPORT_C) begin
                if (mt_on) begin
                    for (int s = 0; s < NUM_SLOTS; s++)
                        if (trk_id[s] >= 0)
                            push(KIND_MOVE, s[5:0], trk_id[s], sx[s], sy[s],
                                 sc ? to_pixels(sx[s], x_min, x_max, scr_w) : '0,
                                 sc ? to_pixels(sy[s], y_min, y_max, scr_h) : '0,
                                 sc, 1'b0);
                end else begin
                    push(KIND_ST, 6'd0, 32'd0, st_x, st_y,
                         sc ? to_pixels(st_x, x_min, x_max, scr_w) : '0,
                         sc ? to_pixels(st_y, y_min, y_max, scr_h) : '0, sc, contact);
                end
            end
            if (pending_reports.size() > n)
                pending_reports[pending_reports.size() - 1][170] = 1'b1;
        endfunction

        function void check_report(logic [1:0] k, logic [167:0] d, logic lst);
            logic [170:0] e;
            if (pending_reports.size() == 0) begin
                $error("unexpected report %h", d);
                errors++;
                return;
            end
            e = pending_reports.pop_front();
            if (e[169:168] != k) begin
                $error("report_kind exp %0d got %0d", e[169:168], k); errors++;
            end
            if (e[5:0] != d[5:0]) begin
                $error("slot_number exp %0d got %0d", e[5:0], d[5:0]); errors++;
            end
            if (e[37:6] != d[37:6]) begin
                $error("track_id exp %h got %h", e[37:6], d[37:6]); errors++;
            end
            if (e[69:38] != d[69:38]) begin
                $error("raw_x exp %h got %h", e[69:38], d[69:38]); errors++;
            end
            if (e[101:70] != d[101:70]) begin
                $error("raw_y exp %h got %h", e[101:70], d[101:70]); errors++;
            end
            if (e[133:102] != d[133:102]) begin
                $error("pixel_x exp %h got %h", e[133:102], d[133:102]); errors++;
            end
            if (e[165:134] != d[165:134]) begin
                $error("pixel_y exp %h got %h", e[165:134], d[165:134]); errors++;
            end
            if (e[166] != d[166]) begin
                $error("scaled exp %0d got %0d", e[166], d[166]); errors++;
            end
            if (e[167] != d[167]) begin
                $error("touching exp %0d got %0d", e[167], d[167]); errors++;
            end
            if (e[170] != lst) begin
                $error("last exp %0d got %0d", e[170], lst); errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1500000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;   // event_code[9:0], event_value[41:10]
    logic [1:0]   s_tuser = '0;   // mode
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [167:0] m_tdata;        // slot_number .. touching, packed from bit 0
    logic [1:0]   m_tuser;        // report_kind
    logic         m_tlast;

    touch_scoreboard sb;
    int  cycles = 0;
    bit  calm = 0;   // while set, neither side idles

    multitouch_event_decoder uut (.*);

    always #5 aclk = ~aclk;

    // Sink side: random back-pressure, check on each accepted word.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_report(m_tuser, m_tdata, m_tlast);
            m_tready <= calm || ($urandom_range(99) >= 32);
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
        @(posedge aclk);
        sb.write_reg(idx, v);
    endtask

    // Block is idle once all reports are in; extra slack covers words
    // that produce no report but still occupy the decoder.
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_reports.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_event(logic [1:0] mode, logic [9:0] code, logic [31:0] val);
        while (!calm && $urandom_range(99) < 32) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, val, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_event(mode, code, val);
    endtask

    task automatic setup(logic signed [31:0] xl, xh, yl, yh, logic [15:0] w, h, logic mt);
        drain();
        cfg_write(REG_XMIN, xl); cfg_write(REG_XMAX, xh);
        cfg_write(REG_YMIN, yl); cfg_write(REG_YMAX, yh);
        cfg_write(REG_SW, {16'd0, w}); cfg_write(REG_SH, {16'd0, h});
        cfg_write(REG_MT, {31'd0, mt});
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return -($urandom_range(4));
            default: return $urandom_range(4095);
        endcase
    endfunction

    // Mostly protocol-B frames with random content, some noise.
    task automatic random_event();
        int r;
        r = $urandom_range(99);
        if (r < 15) send_event(MODE_ABS, MT_SLOT_C,
                               (r < 2) ? pick_value() : $urandom_range(NUM_SLOTS - 1));
        else if (r < 27) send_event(MODE_ABS, ABS_MT_TRK,
                                    $urandom_range(3) == 0 ? -1 : pick_value());
        else if (r < 40) send_event(MODE_ABS, ABS_MT_POS_X, pick_value());
        else if (r < 53) send_event(MODE_ABS, ABS_MT_POS_Y, pick_value());
        else if (r < 60) send_event(MODE_ABS, ABS_X_C, pick_value());
        else if (r < 67) send_event(MODE_ABS, ABS_Y_C, pick_value());
        else if (r < 74) send_event(MODE_KEY, BTN_TOUCH_C,
                                    $urandom_range(1) ? 0 : pick_value());
        else if (r < 90) send_event(MODE_SYNC, SYN_REPORT_C, pick_value());
        else send_event(2'($urandom_range(3)), 10'($urandom_range(1023)), $urandom);
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset-state single-touch report, no scaling.
        send_event(MODE_SYNC, SYN_REPORT_C, 0);
        send_event(MODE_KEY, BTN_TOUCH_C, 32'h8000_0000);
        send_event(MODE_ABS, ABS_X_C, 32'h7fff_ffff);
        send_event(MODE_ABS, ABS_Y_C, 32'h8000_0000);
        send_event(MODE_SYNC, SYN_REPORT_C, 0);
        send_event(MODE_OTHER, 10'h3ff, 32'hffff_ffff);  // ignored kind
        send_event(MODE_SYNC, 10'd5, 0);                 // non-report sync
        send_event(MODE_KEY, 10'd331, 1);                // other key
        send_event(MODE_KEY, BTN_TOUCH_C, 0);
        // Extreme ranges: full 32-bit span, max screen size.
        setup(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              16'hffff, 16'hffff, 1'b1);
        send_event(MODE_SYNC, SYN_REPORT_C, 0);          // no active slot
        send_event(MODE_ABS, ABS_MT_TRK, 32'h7fff_ffff); // down in slot 0
        send_event(MODE_ABS, ABS_MT_POS_X, 32'h7fff_ffff);
        send_event(MODE_ABS, ABS_MT_POS_Y, 32'h8000_0000);
        send_event(MODE_ABS, MT_SLOT_C, NUM_SLOTS - 1);
        send_event(MODE_ABS, ABS_MT_TRK, 0);
        send_event(MODE_ABS, ABS_MT_POS_X, 32'h8000_0000);
        send_event(MODE_SYNC, SYN_REPORT_C, 0);
        send_event(MODE_ABS, MT_SLOT_C, NUM_SLOTS);      // out of range
        send_event(MODE_ABS, ABS_MT_TRK, 5);
        send_event(MODE_ABS, ABS_MT_POS_X, 7);
        send_event(MODE_ABS, MT_SLOT_C, 32'hffff_ffff);
        send_event(MODE_ABS, ABS_MT_TRK, 5);
        send_event(MODE_ABS, MT_SLOT_C, 0);
        send_event(MODE_ABS, ABS_MT_TRK, 32'hffff_ffff); // up
        send_event(MODE_SYNC, SYN_REPORT_C, 0);

        // Random phases across several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 2);
            case (ph)
                0: setup(0, 4095, 0, 4095, 16'd800, 16'd480, 1'b1);
                1: setup(0, 4095, 0, 4095, 16'd800, 16'd480, 1'b0);
                2: setup(-100, 100, 50, 50, 16'd1, 16'd1, 1'b1);  // y range degenerate
                3: setup($urandom, $urandom, $urandom, $urandom,
                         16'($urandom), 16'($urandom), 1'($urandom_range(1)));
                4: setup(100, -100, 0, 10, 16'd640, 16'd0, 1'b0);
                default: setup(32'h8000_0000, 32'h7fff_ffff, -5, 5000,
                               16'hffff, 16'd1, 1'b1);
            endcase
            for (int i = 0; i < 16; i++) random_event();
        end
        calm = 0;

        drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/mted_pkg.sv
rtl/mted_ctrl.sv
rtl/mted_div.sv
rtl/mted_dp.sv
rtl/multitouch_event_decoder.sv
sim/tb.sv
